[rtl/pcm_bucket_envelope_top_assert.svh]
// Assertion macros for the PCM bucket envelope block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PCM_BUCKET_ENVELOPE_TOP_ASSERT_SVH
`define PCM_BUCKET_ENVELOPE_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define PBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pbe_pkg.sv]
// Shared constants and types for the PCM bucket envelope block.
// No dependencies; used by pbe_div and pcm_bucket_envelope_top.
package pbe_pkg;

  localparam int unsigned MAX_BUCKETS_DEF = 64;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned NCNT_W    = 17;
  localparam int unsigned BCNT_W    = 7;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned MEAN_W    = 16;
  localparam int unsigned QBITS_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  localparam logic [7:0] LEVEL_SCALE = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd1;

  // Quotient widths for the three divisions done by the shared divider
  localparam logic [QBITS_W-1:0] QB_STEP  = 5'd17;
  localparam logic [QBITS_W-1:0] QB_MEAN  = 5'd16;
  localparam logic [QBITS_W-1:0] QB_LEVEL = 5'd8;

  typedef struct packed {
    logic                  start;
    logic [SUM_W-1:0]      dividend;
    logic [NCNT_W-1:0]     divisor;
    logic [QBITS_W-1:0]    qbits;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [NCNT_W-1:0] quot;
    logic [NCNT_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/pbe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pbe_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the envelope block.
// Depends on pbe_pkg for the request/response structs.
module pbe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbe_pkg::div_req_t req_i,
  output pbe_pkg::div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [pbe_pkg::QBITS_W-1:0]     cnt_q, cnt_d;
  logic [pbe_pkg::NCNT_W-1:0]      rem_q, rem_d;
  logic [pbe_pkg::NCNT_W-1:0]      quo_q, quo_d;
  logic [pbe_pkg::NCNT_W-1:0]      dsr_q, dsr_d;
  logic [pbe_pkg::SUM_W-1:0]       bits_q, bits_d;
  logic [pbe_pkg::NCNT_W:0]        trial;
  logic [5:0]                      lsh;

  // Caller guarantees dividend >> qbits < divisor, so qbits quotient bits suffice.
  assign lsh   = 6'd32 - {1'b0, req_i.qbits};
  assign trial = {rem_q, bits_q[pbe_pkg::SUM_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    bits_d = bits_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.qbits;
      rem_d  = pbe_pkg::NCNT_W'(req_i.dividend >> req_i.qbits);
      bits_d = req_i.dividend << lsh;
      quo_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = pbe_pkg::NCNT_W'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[pbe_pkg::NCNT_W-2:0], 1'b1};
      end else begin
        rem_d = trial[pbe_pkg::NCNT_W-1:0];
        quo_d = {quo_q[pbe_pkg::NCNT_W-2:0], 1'b0};
      end
      bits_d = bits_q << 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == pbe_pkg::QBITS_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dsr_q  <= dsr_d;
    bits_q <= bits_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/pcm_bucket_envelope_top.sv]
// Top level of the PCM bucket envelope block: control, bucket edges, mean store.
// Depends on pbe_pkg, pbe_ram, pbe_div and pcm_bucket_envelope_top_assert.svh.
//
// Accepts one signed 16-bit sample per item; after sample_count samples it
// emits bucket_count levels (peak-normalized floor means of |sample|), the last
// one flagged. A sample that closes no bucket goes from the check back to idle.
// Closing a bucket that is not empty uses the shared one-bit-per-cycle divider
// (16 quotient bits). Each emitted level takes one RAM read of the mean store,
// then 8 quotient bits of the divider; a silent run skips the divider. A write
// to either register has the divider form sample_count / bucket_count for the
// bucket edges unless bucket_count is zero; items are held off meanwhile. With
// sample_count zero every item emits bucket_count zeros, one per cycle unless
// the output stalls. The mean store needs no clearing after reset.
module pcm_bucket_envelope_top #(
  parameter int unsigned MAX_BUCKETS = pbe_pkg::MAX_BUCKETS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [pbe_pkg::SAMPLE_W-1:0] sample_i,
  // level output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pbe_pkg::LEVEL_W-1:0]     level_o,
  output logic                            last_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pbe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pbe_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NW = pbe_pkg::NCNT_W;
  localparam int unsigned BW = pbe_pkg::BCNT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CFG   = 4'd1;
  localparam logic [3:0] S_DIVC  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_DIVM  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_LV    = 4'd6;
  localparam logic [3:0] S_DIVL  = 4'd7;
  localparam logic [3:0] S_PUT   = 4'd8;

  logic [3:0]                       state_q, state_d;
  logic [NW-1:0]                    ncnt_q, ncnt_d;
  logic [BW-1:0]                    bcnt_q, bcnt_d;
  logic [NW-1:0]                    step_q, step_d;
  logic [BW-1:0]                    stepr_q, stepr_d;
  logic [pbe_pkg::SUM_W-1:0]        sum_q, sum_d;
  logic [NW-1:0]                    sidx_q, sidx_d;
  logic [BW-1:0]                    idx_q, idx_d;
  logic [NW-1:0]                    start_q, start_d;
  logic [NW-1:0]                    end_q, end_d;
  logic [BW-1:0]                    frac_q, frac_d;
  logic [pbe_pkg::MEAN_W-1:0]       peak_q, peak_d;
  logic [pbe_pkg::LEVEL_W-1:0]      lvl_q, lvl_d;
  logic                             out_valid_q, out_valid_d;
  logic [pbe_pkg::LEVEL_W-1:0]      level_q, level_d;
  logic                             last_q, last_d;

  pbe_pkg::div_req_t                div_req;
  pbe_pkg::div_rsp_t                div_rsp;

  logic                             ram_we;
  logic [pbe_pkg::MEAN_W-1:0]       ram_wdata;
  logic [pbe_pkg::MEAN_W-1:0]       ram_rdata;

  logic                             cfg_we;
  logic                             in_acc;
  logic                             close_ok;
  logic                             pend_close;
  logic                             last_k;
  logic                             restart;
  logic [NW-1:0]                    rs_step;
  logic [BW-1:0]                    rs_rem;
  logic [NW-1:0]                    bucket_n;
  logic [BW:0]                      frac_sum;
  logic                             carry;
  logic [NW-1:0]                    end_next;
  logic [BW-1:0]                    frac_next;
  logic [pbe_pkg::SAMPLE_W-1:0]     mag;
  logic [pbe_pkg::MEAN_W-1:0]       mean;
  logic [23:0]                      scaled;
  logic [BW-1:0]                    bsat;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Bucket whose end equals the sample count taken so far must close first.
  assign close_ok   = (idx_q < bcnt_q) && (end_q == sidx_q);
  assign pend_close = (ncnt_q != '0) && close_ok;

  assign in_stall_o = !((state_q == S_IDLE) && !pend_close && !cfg_valid_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign mag = sample_i[pbe_pkg::SAMPLE_W-1] ? pbe_pkg::SAMPLE_W'(~sample_i + 1'b1)
                                             : sample_i;

  assign bucket_n = end_q - start_q;

  // Next edge floor((k+2)N/B) from floor((k+1)N/B): add N/B, carry the N mod B part.
  assign frac_sum  = {1'b0, frac_q} + {1'b0, stepr_q};
  assign carry     = (frac_sum >= {1'b0, bcnt_q});
  assign frac_next = carry ? BW'(frac_sum - {1'b0, bcnt_q}) : frac_sum[BW-1:0];
  assign end_next  = end_q + step_q + NW'(carry);

  assign last_k = ((idx_q + 1'b1) == bcnt_q);
  assign mean   = div_rsp.quot[pbe_pkg::MEAN_W-1:0];
  assign scaled = 24'(ram_rdata) * 24'(pbe_pkg::LEVEL_SCALE);
  assign bsat   = (cfg_data_i[BW-1:0] > BW'(MAX_BUCKETS)) ? BW'(MAX_BUCKETS)
                                                         : cfg_data_i[BW-1:0];

  always_comb begin
    state_d     = state_q;
    ncnt_d      = ncnt_q;
    bcnt_d      = bcnt_q;
    step_d      = step_q;
    stepr_d     = stepr_q;
    sum_d       = sum_q;
    sidx_d      = sidx_q;
    idx_d       = idx_q;
    start_d     = start_q;
    end_d       = end_q;
    frac_d      = frac_q;
    peak_d      = peak_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q;
    level_d     = level_q;
    last_d      = last_q;
    div_req     = '0;
    ram_we      = 1'b0;
    ram_wdata   = '0;
    restart     = 1'b0;
    rs_step     = step_q;
    rs_rem      = stepr_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cfg_we) begin
          unique case (cfg_index_i)
            pbe_pkg::REG_SAMPLE_COUNT: begin
              ncnt_d  = cfg_data_i[NW-1:0];
              state_d = S_CFG;
            end
            pbe_pkg::REG_BUCKET_COUNT: begin
              bcnt_d  = bsat;
              state_d = S_CFG;
            end
            default: ;
          endcase
        end else if (pend_close) begin
          state_d = S_CHECK;
        end else if (in_acc && (bcnt_q != '0)) begin
          if (ncnt_q == '0) begin
            idx_d   = '0;
            lvl_d   = '0;
            state_d = S_PUT;
          end else begin
            sum_d   = sum_q + pbe_pkg::SUM_W'(mag);
            sidx_d  = sidx_q + 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_CFG: begin
        if (bcnt_q == '0) begin
          step_d  = '0;
          stepr_d = '0;
          rs_step = '0;
          rs_rem  = '0;
          restart = 1'b1;
          state_d = S_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = pbe_pkg::SUM_W'(ncnt_q);
          div_req.divisor  = NW'(bcnt_q);
          div_req.qbits    = pbe_pkg::QB_STEP;
          state_d          = S_DIVC;
        end
      end
      S_DIVC: begin
        if (div_rsp.done) begin
          step_d  = div_rsp.quot;
          stepr_d = div_rsp.rem[BW-1:0];
          rs_step = div_rsp.quot;
          rs_rem  = div_rsp.rem[BW-1:0];
          restart = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CHECK: begin
        if (close_ok) begin
          if (bucket_n == '0) begin
            ram_we  = 1'b1;
            idx_d   = idx_q + 1'b1;
            sum_d   = '0;
            start_d = end_q;
            end_d   = end_next;
            frac_d  = frac_next;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_q;
            div_req.divisor  = bucket_n;
            div_req.qbits    = pbe_pkg::QB_MEAN;
            state_d          = S_DIVM;
          end
        end else if (sidx_q == ncnt_q) begin
          idx_d   = '0;
          state_d = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIVM: begin
        if (div_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = mean;
          if (mean > peak_q) begin
            peak_d = mean;
          end
          idx_d   = idx_q + 1'b1;
          sum_d   = '0;
          start_d = end_q;
          end_d   = end_next;
          frac_d  = frac_next;
          state_d = S_CHECK;
        end
      end
      S_RD: begin
        state_d = S_LV;
      end
      S_LV: begin
        if (peak_q == '0) begin
          lvl_d   = '0;
          state_d = S_PUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = pbe_pkg::SUM_W'(scaled);
          div_req.divisor  = NW'(peak_q);
          div_req.qbits    = pbe_pkg::QB_LEVEL;
          state_d          = S_DIVL;
        end
      end
      S_DIVL: begin
        if (div_rsp.done) begin
          lvl_d   = div_rsp.quot[pbe_pkg::LEVEL_W-1:0];
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          level_d     = lvl_q;
          last_d      = last_k;
          if (last_k) begin
            restart = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = (ncnt_q == '0) ? S_PUT : S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (restart) begin
      sum_d   = '0;
      sidx_d  = '0;
      idx_d   = '0;
      start_d = '0;
      end_d   = rs_step;
      frac_d  = rs_rem;
      peak_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ncnt_q      <= '0;
      bcnt_q      <= '0;
      step_q      <= '0;
      stepr_q     <= '0;
      sum_q       <= '0;
      sidx_q      <= '0;
      idx_q       <= '0;
      start_q     <= '0;
      end_q       <= '0;
      frac_q      <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ncnt_q      <= ncnt_d;
      bcnt_q      <= bcnt_d;
      step_q      <= step_d;
      stepr_q     <= stepr_d;
      sum_q       <= sum_d;
      sidx_q      <= sidx_d;
      idx_q       <= idx_d;
      start_q     <= start_d;
      end_q       <= end_d;
      frac_q      <= frac_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    level_q <= level_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign last_o      = last_q;

  pbe_ram #(
    .WIDTH (pbe_pkg::MEAN_W),
    .DEPTH (MAX_BUCKETS)
  ) u_mean_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  pbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

`include "pcm_bucket_envelope_top_assert.svh"

  `PBE_ASSERT(a_div_start_idle, !div_req.start || !div_rsp.busy, "divider restarted while busy")
  `PBE_ASSERT(a_level_fits, !((state_q == S_DIVL) && div_rsp.done) || (div_rsp.quot[NW-1:8] == '0), "level quotient above 255")
  `PBE_ASSERT_NEXT(a_sample_count, in_acc && (bcnt_q != '0) && (ncnt_q != '0), sidx_q == ($past(sidx_q) + 1'b1), "sample index did not advance")
  `PBE_ASSERT_NEXT(a_peak_grows, !restart, peak_q >= $past(peak_q), "peak dropped without restart")

endmodule
